>>> hw/rtl/mesh_vertex_normal_accumulator_defines.svh
// Assertion macros for the vertex normal accumulator.
// No dependencies; included by modules that carry assertions.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MVNA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define MVNA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define MVNA_ASSERT(lbl, clk, rstn, prop, msg)
`define MVNA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

>>> hw/rtl/mvna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
// No dependencies.
package mvna_pkg;
  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;
  localparam int unsigned TALLY_MAX = 255;
  localparam int unsigned SPARSE_LIMIT = 3;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         vid_a;
    logic [9:0]         vid_b;
    logic [9:0]         vid_c;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } mvna_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [7:0]         faces_seen;
    logic               sparse_vertex;
  } mvna_out_t;
endpackage

>>> hw/rtl/mesh_vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator: front queue and back engine.
// Depends on mvna_pkg, mvna_front and mvna_back.
//
//  channel | signals                   | transaction
//  command | start, busy, cmd_i        | start high while busy low
//  result  | result_valid_o, result_o  | one cycle strobe, never stalled
//
// A store is written to the position RAM from idle. A triangle reads three positions,
// forms the cross product, normalizes it and adds it to the three vertex sums; a
// vertex read fetches the sum and normalizes it. The normalizer shifts, squares, takes
// the root, divides and finishes. A zero vector skips the divides.
// After reset every slot of the sum RAM is cleared while busy is high.
// busy rises when the two-entry command queue is full.
module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
  parameter int VERTEX_SLOTS = 1024,
  parameter int SUM_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  mvna_in_t  cmd_i,
  output logic      busy,
  output logic      result_valid_o,
  output mvna_out_t result_o
);
  logic     q_valid, q_pop, f_busy, clr_busy;
  mvna_in_t q_cmd;

  assign busy = f_busy || clr_busy;

  mvna_front u_front (
    .clk_i, .rst_ni, .start_i(start && !clr_busy), .cmd_i, .busy_o(f_busy),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop));

  mvna_back #(.VertexSlots(VERTEX_SLOTS), .SumBits(SUM_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .clr_busy_o(clr_busy), .res_valid_o(result_valid_o), .res_o(result_o));
endmodule

>>> hw/rtl/mvna_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mvna_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/mvna_front.sv
// Front end: accepts commands, drops ignored ones, and feeds a two-entry queue.
// Depends on mvna_pkg.
module mvna_front import mvna_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  mvna_in_t cmd_i,
  output logic     busy_o,
  output logic     q_valid_o,
  output mvna_in_t q_cmd_o,
  input  logic     q_pop_i
);
  mvna_in_t   ent_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push, keep;

  assign busy_o    = (cnt_q == 2'd2);
  assign keep      = (cmd_i.op != OP_NOP);
  assign push      = start_i && !busy_o && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

>>> hw/rtl/mvna_norm.sv
// Normalizer: bit-serial square root and three serial restoring divides.
// Depends on mvna_pkg and the assertion macro header.
`include "mesh_vertex_normal_accumulator_defines.svh"
module mvna_norm import mvna_pkg::*; #(
  parameter int InBits = 33
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic signed [InBits-1:0] cx_i,
  input  logic signed [InBits-1:0] cy_i,
  input  logic signed [InBits-1:0] cz_i,
  output logic                     done_o,
  output logic signed [15:0]       nx_o,
  output logic signed [15:0]       ny_o,
  output logic signed [15:0]       nz_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHR  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam int MagBits = (InBits > 30) ? InBits : 30;

  logic [2:0]         st_q;
  logic [MagBits-1:0] m_q [3];
  logic [2:0]         neg_q;
  logic [63:0]        sq_q, rem_q, res_q, bit_q;
  logic [1:0]         sqi_q, ci_q;
  logic [5:0]         step_q;
  logic [45:0]        num_q;
  logic [31:0]        len_q;
  logic [44:0]        dr_q;
  logic [15:0]        quo_q;
  logic signed [15:0] n_q [3];
  logic               big;
  logic [61:0]        prod;
  logic [45:0]        trial;

  assign big  = (m_q[0] >= MagBits'(1 << 30)) || (m_q[1] >= MagBits'(1 << 30))
             || (m_q[2] >= MagBits'(1 << 30));
  assign prod = m_q[sqi_q][30:0] * m_q[sqi_q][30:0];
  assign trial = {dr_q, num_q[45]} ;

  assign done_o = (st_q == S_FIN);
  assign nx_o = n_q[0];
  assign ny_o = n_q[1];
  assign nz_o = n_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (go_i) begin
            st_q <= S_SHR;
          end
        end
        S_SHR:  if (!big) st_q <= S_SQ;
        S_SQ:   if (sqi_q == 2'd2) st_q <= S_SQRT;
        S_SQRT: if (bit_q == 64'd0) st_q <= (res_q == 64'd0) ? S_FIN : S_DIV;
        S_DIV:  if (ci_q == 2'd2 && step_q == 6'd45) st_q <= S_FIN;
        S_FIN:  st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        m_q[0] <= cx_i[InBits-1] ? MagBits'(-cx_i) : MagBits'(cx_i);
        m_q[1] <= cy_i[InBits-1] ? MagBits'(-cy_i) : MagBits'(cy_i);
        m_q[2] <= cz_i[InBits-1] ? MagBits'(-cz_i) : MagBits'(cz_i);
        neg_q  <= {cz_i[InBits-1], cy_i[InBits-1], cx_i[InBits-1]};
        sqi_q  <= 2'd0;
        sq_q   <= 64'd0;
        n_q[0] <= '0;
        n_q[1] <= '0;
        n_q[2] <= '0;
      end
      S_SHR: begin
        if (big) begin
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end
      end
      S_SQ: begin
        sq_q  <= sq_q + {2'b0, prod};
        sqi_q <= sqi_q + 2'd1;
        rem_q <= sq_q + {2'b0, prod};
        res_q <= 64'd0;
        bit_q <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (bit_q != 64'd0) begin
          if (rem_q >= res_q + bit_q) begin
            rem_q <= rem_q - (res_q + bit_q);
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          len_q  <= res_q[31:0];
          ci_q   <= 2'd0;
          step_q <= 6'd0;
          num_q  <= {2'b0, m_q[0][29:0], 14'd0} + {14'd0, 1'b0, res_q[31:1]};
          dr_q   <= '0;
        end
      end
      S_DIV: begin
        // Restoring divide, one quotient bit per cycle over a 46-bit numerator.
        if (trial >= {14'd0, len_q}) begin
          dr_q  <= 45'(trial - {14'd0, len_q});
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          dr_q  <= trial[44:0];
          quo_q <= {quo_q[14:0], 1'b0};
        end
        num_q <= num_q << 1;
        if (step_q == 6'd45) begin
          step_q <= 6'd0;
          ci_q   <= ci_q + 2'd1;
          dr_q   <= '0;
          n_q[ci_q] <= neg_q[ci_q]
            ? -$signed({quo_q[14:0], trial >= {14'd0, len_q}})
            :  $signed({quo_q[14:0], trial >= {14'd0, len_q}});
          if (ci_q != 2'd2) begin
            num_q <= {2'b0, m_q[ci_q + 2'd1][29:0], 14'd0}
                   + {14'd0, 1'b0, len_q[31:1]};
          end
        end else begin
          step_q <= step_q + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  `MVNA_ASSERT_NEXT(a_fin_one, clk_i, rst_ni, done_o, !done_o, "done held")
  `MVNA_ASSERT(a_q_bound, clk_i, rst_ni, !(st_q == S_DIV && ci_q == 2'd3), "div index")
  `MVNA_ASSERT_NEXT(a_go_idle, clk_i, rst_ni, (st_q == S_IDLE && go_i), st_q == S_SHR,
                    "no start")
endmodule

>>> hw/rtl/mvna_back.sv
// Back end: position cross product, normalization and sum updates over RAMs.
// Depends on mvna_pkg, mvna_ram, mvna_norm and the assertion macro header.
`include "mesh_vertex_normal_accumulator_defines.svh"
module mvna_back import mvna_pkg::*; #(
  parameter int VertexSlots = 1024,
  parameter int SumBits = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  mvna_in_t  q_cmd_i,
  output logic      q_pop_o,
  output logic      clr_busy_o,
  output logic      res_valid_o,
  output mvna_out_t res_o
);
  localparam int AW = $clog2(VertexSlots);
  localparam int SW = 3 * SumBits + 8;
  // Normalizer input width: wide enough for a cross product and for a sum.
  localparam int NB = (SumBits > 36) ? SumBits : 36;
  localparam logic [3:0] B_CLR = 4'd0, B_IDLE = 4'd1, B_RD = 4'd2, B_RDW = 4'd3,
                         B_CROSS = 4'd4, B_MUL = 4'd5, B_NORM = 4'd6, B_NWAIT = 4'd7,
                         B_UPD = 4'd8, B_UPW = 4'd9, B_UPWR = 4'd10, B_OUT = 4'd11;

  logic [3:0]    st_q;
  logic [AW:0]   clr_q;
  mvna_in_t      c_q;
  logic [1:0]    k_q;
  logic signed [15:0] p_q [3][3];
  logic signed [16:0] a_q [3], b_q [3];
  logic signed [33:0] pr_q [6];
  logic signed [SumBits-1:0] s_q [3];
  logic [7:0]    cnt_q;
  logic          pos_we, sum_we;
  logic [AW-1:0] pos_addr, sum_addr;
  logic [47:0]   pos_rd;
  logic [SW-1:0] sum_wd, sum_rd;
  logic [9:0]    vid_k, vid_d;
  logic          in_rng, ng_go, ng_done;
  logic signed [NB-1:0] ex, ey, ez;
  logic signed [15:0] nx, ny, nz;
  logic signed [15:0] f_q [3];
  logic signed [SumBits:0] t [3];
  logic signed [SumBits-1:0] sat [3];

  always_comb begin
    case (k_q)
      2'd0:    vid_k = c_q.vid_a;
      2'd1:    vid_k = c_q.vid_b;
      default: vid_k = c_q.vid_c;
    endcase
  end
  // Slot ids beyond the parameter range never touch the stores.
  assign in_rng   = ({22'd0, vid_k} < 32'(VertexSlots));
  assign vid_d    = q_cmd_i.vid_a;
  assign pos_we   = (st_q == B_IDLE) && q_valid_i && (q_cmd_i.op == OP_STORE)
                 && ({22'd0, vid_d} < 32'(VertexSlots));
  assign pos_addr = pos_we ? AW'(vid_d) : AW'(vid_k);
  assign sum_addr = (st_q == B_CLR) ? clr_q[AW-1:0] : AW'(vid_k);
  assign sum_we   = (st_q == B_CLR) || ((st_q == B_UPWR) && in_rng);
  assign q_pop_o  = (st_q == B_IDLE) && q_valid_i;
  assign clr_busy_o = (st_q == B_CLR);

  for (genvar i = 0; i < 3; i++) begin : g_sat
    assign t[i] = $signed({s_q[i][SumBits-1], s_q[i]}) + (SumBits+1)'(f_q[i]);
    assign sat[i] = (t[i][SumBits] != t[i][SumBits-1])
      ? {t[i][SumBits], {(SumBits-1){~t[i][SumBits]}}} : t[i][SumBits-1:0];
  end
  assign sum_wd = (st_q == B_CLR) ? '0 :
    {sat[0], sat[1], sat[2], (cnt_q == 8'(TALLY_MAX)) ? cnt_q : cnt_q + 8'd1};

  mvna_ram #(.Width(48), .Depth(VertexSlots)) u_pos (
    .clk_i, .we_i(pos_we), .addr_i(pos_addr),
    .wdata_i({q_cmd_i.pos_x, q_cmd_i.pos_y, q_cmd_i.pos_z}), .rdata_o(pos_rd));
  mvna_ram #(.Width(SW), .Depth(VertexSlots)) u_sum (
    .clk_i, .we_i(sum_we), .addr_i(sum_addr), .wdata_i(sum_wd), .rdata_o(sum_rd));

  assign ex = (c_q.op == OP_TRI) ? (NB'(pr_q[0]) - NB'(pr_q[1])) : NB'(s_q[0]);
  assign ey = (c_q.op == OP_TRI) ? (NB'(pr_q[2]) - NB'(pr_q[3])) : NB'(s_q[1]);
  assign ez = (c_q.op == OP_TRI) ? (NB'(pr_q[4]) - NB'(pr_q[5])) : NB'(s_q[2]);
  assign ng_go = (st_q == B_NORM);

  mvna_norm #(.InBits(NB)) u_norm (
    .clk_i, .rst_ni, .go_i(ng_go), .cx_i(ex), .cy_i(ey), .cz_i(ez),
    .done_o(ng_done), .nx_o(nx), .ny_o(ny), .nz_o(nz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_CLR;
      clr_q       <= '0;
      res_valid_o <= 1'b0;
      k_q         <= 2'd0;
    end else begin
      res_valid_o <= 1'b0;
      case (st_q)
        B_CLR: begin
          clr_q <= clr_q + (AW+1)'(1);
          if (clr_q == (AW+1)'(VertexSlots - 1)) st_q <= B_IDLE;
        end
        B_IDLE: begin
          k_q <= 2'd0;
          if (q_valid_i && q_cmd_i.op == OP_TRI) st_q <= B_RD;
          if (q_valid_i && q_cmd_i.op == OP_READ) st_q <= B_RD;
        end
        B_RD:  st_q <= B_RDW;
        B_RDW: begin
          if (c_q.op == OP_READ) begin
            st_q <= B_NORM;
          end else if (k_q == 2'd2) begin
            st_q <= B_CROSS;
          end else begin
            k_q <= k_q + 2'd1;
            st_q <= B_RD;
          end
        end
        B_CROSS: st_q <= B_MUL;
        B_MUL:   st_q <= B_NORM;
        B_NORM:  st_q <= B_NWAIT;
        B_NWAIT: begin
          if (ng_done) begin
            k_q  <= 2'd0;
            st_q <= (c_q.op == OP_TRI) ? B_UPD : B_OUT;
          end
        end
        B_UPD:  st_q <= B_UPW;
        B_UPW:  st_q <= B_UPWR;
        B_UPWR: begin
          if (k_q == 2'd2) begin
            st_q <= B_OUT;
          end else begin
            k_q  <= k_q + 2'd1;
            st_q <= B_UPD;
          end
        end
        B_OUT: begin
          res_valid_o <= 1'b1;
          st_q <= B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_IDLE: c_q <= q_cmd_i;
      B_RDW: begin
        if (c_q.op == OP_READ) begin
          s_q[0] <= in_rng ? sum_rd[SW-1 -: SumBits] : '0;
          s_q[1] <= in_rng ? sum_rd[SW-1-SumBits -: SumBits] : '0;
          s_q[2] <= in_rng ? sum_rd[SW-1-2*SumBits -: SumBits] : '0;
          cnt_q  <= in_rng ? sum_rd[7:0] : 8'd0;
        end else begin
          p_q[k_q][0] <= in_rng ? pos_rd[47:32] : '0;
          p_q[k_q][1] <= in_rng ? pos_rd[31:16] : '0;
          p_q[k_q][2] <= in_rng ? pos_rd[15:0]  : '0;
        end
      end
      B_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          a_q[i] <= 17'(p_q[1][i]) - 17'(p_q[0][i]);
          b_q[i] <= 17'(p_q[2][i]) - 17'(p_q[0][i]);
        end
      end
      B_MUL: begin
        pr_q[0] <= a_q[1] * b_q[2];
        pr_q[1] <= a_q[2] * b_q[1];
        pr_q[2] <= a_q[2] * b_q[0];
        pr_q[3] <= a_q[0] * b_q[2];
        pr_q[4] <= a_q[0] * b_q[1];
        pr_q[5] <= a_q[1] * b_q[0];
      end
      B_NWAIT: begin
        f_q[0] <= nx;
        f_q[1] <= ny;
        f_q[2] <= nz;
      end
      B_UPW: begin
        s_q[0] <= sum_rd[SW-1 -: SumBits];
        s_q[1] <= sum_rd[SW-1-SumBits -: SumBits];
        s_q[2] <= sum_rd[SW-1-2*SumBits -: SumBits];
        cnt_q  <= sum_rd[7:0];
      end
      B_OUT: begin
        res_o.kind          <= (c_q.op == OP_READ);
        res_o.norm_x        <= f_q[0];
        res_o.norm_y        <= f_q[1];
        res_o.norm_z        <= f_q[2];
        res_o.faces_seen    <= (c_q.op == OP_READ) ? cnt_q : 8'd0;
        res_o.sparse_vertex <= (c_q.op == OP_READ) && (cnt_q < 8'(SPARSE_LIMIT));
      end
      default: begin
      end
    endcase
  end

  `MVNA_ASSERT(a_clr_quiet, clk_i, rst_ni, !(clr_busy_o && q_pop_o), "pop in clear")
  `MVNA_ASSERT(a_we_excl, clk_i, rst_ni, !(pos_we && sum_we), "double write")
  `MVNA_ASSERT_NEXT(a_out, clk_i, rst_ni, st_q == B_OUT, res_valid_o, "lost result")
endmodule
